// ===== sv/atm_pkg.sv =====
`default_nettype none
package atm_pkg;

  localparam int unsigned HALF_W = 32;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned DIV_W  = 16;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // timer register map seen by write/read items
  typedef enum logic [3:0] {
    RA_CONTROL = 4'd0,
    RA_LOADLO  = 4'd1,
    RA_LOADHI  = 4'd2,
    RA_LOAD    = 4'd3,
    RA_LATCH   = 4'd4,
    RA_COUNTLO = 4'd5,
    RA_COUNTHI = 4'd6,
    RA_INTENA  = 4'd7,
    RA_INTRAW  = 4'd8,
    RA_INTCLR  = 4'd9
  } reg_addr_t;

  // configuration port register indexes
  typedef enum logic [1:0] {
    CFG_DIVIDER     = 2'd0,
    CFG_COUNT_UP    = 2'd1,
    CFG_AUTO_RELOAD = 2'd2,
    CFG_ALARM_VALUE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIV_W-1:0] divider;
    logic             count_up;
    logic             auto_reload;
    logic [CNT_W-1:0] alarm_value;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/atm_cfg.sv =====
`default_nettype none
module atm_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready,
  output atm_pkg::cfg_t     cfg
);
  import atm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  cfg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_idx_t'(cfg_paddr[4:3]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        CFG_DIVIDER:     cfg_nxt.divider     = cfg_pwdata[DIV_W-1:0];
        CFG_COUNT_UP:    cfg_nxt.count_up    = cfg_pwdata[0];
        CFG_AUTO_RELOAD: cfg_nxt.auto_reload = cfg_pwdata[0];
        CFG_ALARM_VALUE: cfg_nxt.alarm_value = cfg_pwdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_DIVIDER:     cfg_prdata = {{(64-DIV_W){1'b0}}, cfg_r.divider};
      CFG_COUNT_UP:    cfg_prdata = {63'd0, cfg_r.count_up};
      CFG_AUTO_RELOAD: cfg_prdata = {63'd0, cfg_r.auto_reload};
      CFG_ALARM_VALUE: cfg_prdata = cfg_r.alarm_value;
      default:         cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.divider     <= DIV_W'(1);
      cfg_r.count_up    <= 1'b1;
      cfg_r.auto_reload <= 1'b1;
      cfg_r.alarm_value <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/atm_core.sv =====
`default_nettype none
module atm_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire atm_pkg::cfg_t        cfg,
  input  wire logic                 fire,
  input  wire atm_pkg::kind_t       kind,
  input  wire logic [3:0]           reg_address,
  input  wire logic [31:0]          write_data,
  output logic [31:0]               read_data,
  output logic                      interrupt_line
);
  import atm_pkg::*;

  logic [CNT_W-1:0] counter_r, counter_nxt;
  logic [DIV_W-1:0] prescale_r, prescale_nxt;
  logic [CNT_W-1:0] load_r, load_nxt;
  logic [CNT_W-1:0] latched_r, latched_nxt;
  logic             run_r, run_nxt;
  logic             alarm_en_r, alarm_en_nxt;
  logic             level_en_r, level_en_nxt;
  logic             irq_en_r, irq_en_nxt;
  logic             irq_raw_r, irq_raw_nxt;

  logic [DIV_W:0]   ratio;
  logic [DIV_W:0]   pre_inc;
  logic             pre_wrap;
  logic [CNT_W-1:0] cnt_step;
  reg_addr_t        addr;

  assign addr = reg_addr_t'(reg_address);

  // 0 selects 65536, 1 selects 2
  always_comb begin
    if (cfg.divider == '0) begin
      ratio = {1'b1, {DIV_W{1'b0}}};
    end else if (cfg.divider == DIV_W'(1)) begin
      ratio = (DIV_W+1)'(2);
    end else begin
      ratio = {1'b0, cfg.divider};
    end
  end

  assign pre_inc  = {1'b0, prescale_r} + (DIV_W+1)'(1);
  assign pre_wrap = pre_inc >= ratio;

  always_comb begin
    if (run_r && pre_wrap) begin
      cnt_step = cfg.count_up ? counter_r + CNT_W'(1) : counter_r - CNT_W'(1);
    end else begin
      cnt_step = counter_r;
    end
  end

  always_comb begin
    counter_nxt  = counter_r;
    prescale_nxt = prescale_r;
    load_nxt     = load_r;
    latched_nxt  = latched_r;
    run_nxt      = run_r;
    alarm_en_nxt = alarm_en_r;
    level_en_nxt = level_en_r;
    irq_en_nxt   = irq_en_r;
    irq_raw_nxt  = irq_raw_r;
    read_data    = 32'd0;
    if (fire) begin
      case (kind)
        KIND_TICK: begin
          if (run_r) begin
            prescale_nxt = pre_wrap ? '0 : pre_inc[DIV_W-1:0];
          end
          counter_nxt = cnt_step;
          // compare runs on the post-step count, even when stopped
          if (alarm_en_r && cnt_step == cfg.alarm_value) begin
            irq_raw_nxt  = 1'b1;
            alarm_en_nxt = 1'b0;
            if (cfg.auto_reload) begin
              counter_nxt = load_r;
            end
          end
        end
        KIND_WRITE: begin
          case (addr)
            RA_CONTROL: begin
              run_nxt      = write_data[0];
              alarm_en_nxt = write_data[1];
              level_en_nxt = write_data[2];
            end
            RA_LOADLO: load_nxt[HALF_W-1:0]     = write_data;
            RA_LOADHI: load_nxt[CNT_W-1:HALF_W] = write_data;
            RA_LOAD:   counter_nxt = load_r;
            RA_LATCH:  latched_nxt = counter_r;
            RA_INTENA: irq_en_nxt  = write_data[0];
            RA_INTCLR: begin
              if (write_data[0]) begin
                irq_raw_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
        KIND_READ: begin
          case (addr)
            RA_CONTROL: read_data = {29'd0, level_en_r, alarm_en_r, run_r};
            RA_LOADLO:  read_data = load_r[HALF_W-1:0];
            RA_LOADHI:  read_data = load_r[CNT_W-1:HALF_W];
            RA_COUNTLO: read_data = latched_r[HALF_W-1:0];
            RA_COUNTHI: read_data = latched_r[CNT_W-1:HALF_W];
            RA_INTENA:  read_data = {31'd0, irq_en_r};
            RA_INTRAW:  read_data = {31'd0, irq_raw_r};
            default:    read_data = 32'd0;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign interrupt_line = irq_raw_nxt && irq_en_nxt && level_en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r  <= '0;
      prescale_r <= '0;
      load_r     <= '0;
      latched_r  <= '0;
      run_r      <= 1'b0;
      alarm_en_r <= 1'b0;
      level_en_r <= 1'b0;
      irq_en_r   <= 1'b0;
      irq_raw_r  <= 1'b0;
    end else begin
      counter_r  <= counter_nxt;
      prescale_r <= prescale_nxt;
      load_r     <= load_nxt;
      latched_r  <= latched_nxt;
      run_r      <= run_nxt;
      alarm_en_r <= alarm_en_nxt;
      level_en_r <= level_en_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_raw_r  <= irq_raw_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/alarm_timer_64bit_top.sv =====
`default_nettype none
// 64-bit timer with a 16-bit prescaler, alarm compare and autoreload. Each
// input item is a tick (in_tuser = 0), a register write (1) or a register
// read (2); every item yields exactly one result item carrying read data
// (zero unless a read) and the level interrupt as it stands after the item.
// An item is captured in an input register and, in the cycle it moves on,
// updates the timer state and lands in the output register; one item is
// accepted every clock unless the result side stalls, and the output
// register lets a new item enter while an earlier result waits. Divider,
// count direction, autoreload and the 64-bit alarm value sit on the APB
// port at byte addresses 0, 8, 16 and 24 and are meant to change only
// while no item is in flight.
module alarm_timer_64bit_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [3:0] reg_address, [35:4] write_data, rest 0
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] read_data, [32] interrupt_line, rest 0
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import atm_pkg::*;

  cfg_t        cfg;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  kind_t       s1_kind_r;
  logic [3:0]  s1_addr_r;
  logic [31:0] s1_data_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_rd_r;
  logic        out_irq_r;

  logic        advance;
  logic        in_fire;
  logic [31:0] core_rd;
  logic        core_irq;

  // item moves into the output register when that slot is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  atm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  atm_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .fire           (advance),
    .kind           (s1_kind_r),
    .reg_address    (s1_addr_r),
    .write_data     (s1_data_r),
    .read_data      (core_rd),
    .interrupt_line (core_irq)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= kind_t'(in_tuser);
      s1_addr_r <= in_tdata[3:0];
      s1_data_r <= in_tdata[35:4];
    end
    if (advance) begin
      out_rd_r  <= core_rd;
      out_irq_r <= core_irq;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_irq_r, out_rd_r};

  // a held item must not be dropped while the result side stalls
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("input item lost during output stall");

  // an empty input register always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready while input register empty");

  // only reads return data
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_kind_r != KIND_READ) |=> (out_tdata[31:0] == 32'd0))
    else $error("non-read item produced read data");

  // a result leaves the output register only through the handshake
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && !advance) |=> out_valid_r)
    else $error("result dropped without handshake");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Standalone bench for the 64-bit alarm timer. A directed table runs first,
// then twelve phases of constrained-random items, each under its own
// divider / direction / autoreload / alarm setting. Every accepted input
// item is run through a local timer predictor. The result it predicts is
// queued and compared, field by field, with the result item that comes out.
module tb_top;
  import atm_pkg::*;

  // codes the package does not name
  localparam logic [1:0] KIND_NONE      = 2'd3;   // unused kind, a no-op
  localparam logic [3:0] RA_UNMAPPED_LO = 4'd10;  // first address with no register
  localparam logic [3:0] RA_UNMAPPED_HI = 4'd15;
  localparam int CTRL_RUN   = 0;                  // control register bits
  localparam int CTRL_ALARM = 1;
  localparam int CTRL_LEVEL = 2;
  localparam bit PREDICT = 1'b0;                  // table row: use the predictor
  localparam bit TYPED   = 1'b1;                  // table row: expectation typed in
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 135;
  localparam int MAX_GAP     = 18;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
  } timer_result_t;

  typedef struct packed {
    int unsigned   seq;
    timer_result_t res;
  } pending_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  addr;
    logic [31:0] data;
    bit          typed;
    logic [31:0] rd;
    logic        irq;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [3:0] reg_address, [35:4] write_data, rest 0
  logic [1:0]  in_tuser = '0;    // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [31:0] read_data, [32] interrupt_line, rest 0
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // configuration copy, at its reset values
  logic [15:0] cfg_divider = 16'd1;
  logic        cfg_count_up = 1'b1;
  logic        cfg_auto_reload = 1'b1;
  logic [63:0] cfg_alarm = '0;

  // predicted timer state, at its reset values
  logic [63:0] t_counter = '0;
  logic [15:0] t_prescale = '0;
  logic [63:0] t_load = '0;
  logic [63:0] t_latched = '0;
  logic        t_run = 1'b0;
  logic        t_alarm_en = 1'b0;
  logic        t_level_en = 1'b0;
  logic        t_irq_en = 1'b0;
  logic        t_irq_raw = 1'b0;

  pending_t    pending_results [$];
  bit          no_idle = 1'b0;     // phase without gaps on either side
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned alarm_hits = 0;
  int unsigned settings_used = 1;

  alarm_timer_64bit_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Applies one item to the predicted state and returns the result it yields.
  function automatic timer_result_t timer_predict(logic [1:0] kind, logic [3:0] addr,
                                                  logic [31:0] data);
    timer_result_t r;
    logic [16:0]   ratio;
    r = '0;
    if (kind == KIND_TICK) begin
      if (t_run) begin
        // 0 divides by 65536, 1 by 2
        if (cfg_divider == 16'd0) ratio = 17'd65536;
        else if (cfg_divider == 16'd1) ratio = 17'd2;
        else ratio = {1'b0, cfg_divider};
        // a count left above a lowered ratio also wraps
        if ({1'b0, t_prescale} + 17'd1 >= ratio) begin
          t_prescale = '0;
          t_counter = cfg_count_up ? t_counter + 64'd1 : t_counter - 64'd1;
        end else begin
          t_prescale = t_prescale + 16'd1;
        end
      end
      // compare runs on every tick, stopped or not
      if (t_alarm_en && t_counter == cfg_alarm) begin
        t_irq_raw = 1'b1;
        t_alarm_en = 1'b0;
        alarm_hits++;
        if (cfg_auto_reload) t_counter = t_load;
      end
    end else if (kind == KIND_WRITE) begin
      case (addr)
        RA_CONTROL: begin
          t_run = data[CTRL_RUN];
          t_alarm_en = data[CTRL_ALARM];
          t_level_en = data[CTRL_LEVEL];
        end
        RA_LOADLO: t_load[31:0] = data;
        RA_LOADHI: t_load[63:32] = data;
        RA_LOAD:   t_counter = t_load;
        RA_LATCH:  t_latched = t_counter;
        RA_INTENA: t_irq_en = data[0];
        RA_INTCLR: if (data[0]) t_irq_raw = 1'b0;
        default: ;
      endcase
    end else if (kind == KIND_READ) begin
      case (addr)
        RA_CONTROL: r.rd = {29'd0, t_level_en, t_alarm_en, t_run};
        RA_LOADLO:  r.rd = t_load[31:0];
        RA_LOADHI:  r.rd = t_load[63:32];
        RA_COUNTLO: r.rd = t_latched[31:0];
        RA_COUNTHI: r.rd = t_latched[63:32];
        RA_INTENA:  r.rd = {31'd0, t_irq_en};
        RA_INTRAW:  r.rd = {31'd0, t_irq_raw};
        default:    r.rd = '0;
      endcase
    end
    r.irq = t_irq_raw & t_irq_en & t_level_en;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] kind, logic [3:0] addr, logic [31:0] data,
                                      bit typed, logic [31:0] rd, logic irq);
    return '{kind, addr, data, typed, rd, irq};
  endfunction

  // Sends one item after a random gap. Returns at the accept edge with
  // in_tvalid still high: the caller either sends the next item at once
  // or lowers in_tvalid, so the signal never sees two updates in one step.
  task automatic push_item(input logic [1:0] kind, input logic [3:0] addr,
                           input logic [31:0] data, input bit typed,
                           input timer_result_t typed_res);
    int unsigned   gap;
    timer_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'd0, data, addr};
    do @(posedge clk); while (!in_tready);
    res = timer_predict(kind, addr, data);
    if (typed) res = typed_res;
    pending_results.push_back('{items_sent, res});
    items_sent++;
  endtask

  // APB write: setup, access, then idle, so calls can follow back to back.
  task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DIVIDER:     cfg_divider = value[15:0];
      CFG_COUNT_UP:    cfg_count_up = value[0];
      CFG_AUTO_RELOAD: cfg_auto_reload = value[0];
      default:         cfg_alarm = value;
    endcase
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("tb_top: %s", msg);
  endtask

  // Result side: random stall per item, then wait for a result and check it
  // against the oldest expectation.
  initial begin
    int unsigned stall;
    pending_t    want;
    logic [31:0] got_rd;
    logic        got_irq;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_rd = out_tdata[31:0];
      got_irq = out_tdata[32];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: read_data %h interrupt_line %b",
                                got_rd, got_irq));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got_rd !== want.res.rd || got_irq !== want.res.irq)
          note_mismatch($sformatf("item %0d: read_data exp %h got %h, interrupt_line exp %b got %b",
                                  want.seq, want.res.rd, got_rd, want.res.irq, got_irq));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    dir_row_t      dir_rows [$];
    dir_row_t      row;
    logic [15:0]   div;
    logic          up;
    logic          reload;
    logic [63:0]   base;
    logic [63:0]   alarm;
    int unsigned   off;
    int unsigned   pick;
    logic [1:0]    kind;
    logic [3:0]    addr;
    logic [31:0]   data;

    // Directed table. The timer starts at reset: ratio 2, counting up,
    // autoreload on, alarm at zero.
    dir_rows = '{
      // reset values, unmapped read, unused kind, tick while stopped
      mk_row(KIND_READ,  RA_CONTROL,     32'h0000_0000, TYPED,   32'h0, 1'b0),
      mk_row(KIND_READ,  RA_UNMAPPED_HI, 32'hFFFF_FFFF, TYPED,   32'h0, 1'b0),
      mk_row(KIND_NONE,  RA_CONTROL,     32'hFFFF_FFFF, TYPED,   32'h0, 1'b0),
      mk_row(KIND_TICK,  RA_CONTROL,     32'h0000_0000, TYPED,   32'h0, 1'b0),
      // load value of all ones, counter one step short of wrapping
      mk_row(KIND_WRITE, RA_LOADLO,      32'hFFFF_FFFF, TYPED,   32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_LOADHI,      32'hFFFF_FFFF, TYPED,   32'h0, 1'b0),
      mk_row(KIND_READ,  RA_LOADLO,      32'h0000_0000, TYPED,   32'hFFFF_FFFF, 1'b0),
      mk_row(KIND_WRITE, RA_LOAD,        32'h0000_0000, PREDICT, 32'h0, 1'b0),
      // all-ones data: upper bits must be dropped
      mk_row(KIND_WRITE, RA_INTENA,      32'hFFFF_FFFF, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_CONTROL,     32'hFFFF_FFFF, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_READ,  RA_CONTROL,     32'h0000_0000, TYPED,   32'h7, 1'b0),
      // second tick wraps 64 bits to zero, hits the alarm and reloads
      mk_row(KIND_TICK,  RA_CONTROL,     32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_TICK,  RA_CONTROL,     32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_READ,  RA_INTRAW,      32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_LATCH,       32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_READ,  RA_COUNTHI,     32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_INTCLR,      32'h0000_0001, PREDICT, 32'h0, 1'b0),
      // counter to zero, alarm armed with the timer stopped
      mk_row(KIND_WRITE, RA_LOADLO,      32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_LOADHI,      32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_LOAD,        32'h0000_0000, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_CONTROL,     32'h0000_0002, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_TICK,  RA_CONTROL,     32'h0000_0000, PREDICT, 32'h0, 1'b0),
      // writes with no effect
      mk_row(KIND_WRITE, RA_UNMAPPED_LO, 32'hFFFF_FFFF, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_WRITE, RA_COUNTLO,     32'hFFFF_FFFF, PREDICT, 32'h0, 1'b0),
      mk_row(KIND_READ,  RA_INTRAW,      32'h0000_0000, PREDICT, 32'h0, 1'b0)
    };

    // single reset at the start of the run
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      push_item(row.kind, row.addr, row.data, row.typed, '{row.rd, row.irq});
    end

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      // settings change only once the timer is empty
      in_tvalid <= 1'b0;
      drain_results();
      repeat (4) @(posedge clk);

      // first four phases pin the extremes; the prescaler keeps its count
      // across phases, so lowering the divider hits the wrap-above-ratio case
      case (ph)
        0: div = 16'd0;
        1: div = 16'd1;
        2: div = 16'hFFFF;
        3: div = 16'd2;
        default: div = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
      endcase
      up = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      reload = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
      off = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        // near the 64-bit wrap point
        base = 64'($urandom_range(0, 8));
        if ($urandom_range(0, 1) != 0) base = ~base;
      end else begin
        base = {$urandom, $urandom};
      end
      alarm = up ? base + 64'(off) : base - 64'(off);
      if (ph == 1) begin
        alarm = '1;
        base = alarm - 64'(off);
      end
      if (ph == 2) begin
        alarm = '0;
        base = alarm + 64'(off);
      end
      cfg_write(CFG_DIVIDER, {48'd0, div});
      cfg_write(CFG_COUNT_UP, {63'd0, up});
      cfg_write(CFG_AUTO_RELOAD, {63'd0, reload});
      cfg_write(CFG_ALARM_VALUE, alarm);
      settings_used++;
      no_idle = (ph % 4 == 3);

      // arm the timer: counter a few steps from the alarm, interrupt enabled
      push_item(KIND_WRITE, RA_LOADLO, base[31:0], PREDICT, '0);
      push_item(KIND_WRITE, RA_LOADHI, base[63:32], PREDICT, '0);
      push_item(KIND_WRITE, RA_LOAD, $urandom, PREDICT, '0);
      push_item(KIND_WRITE, RA_INTENA, $urandom | 32'd1, PREDICT, '0);
      push_item(KIND_WRITE, RA_INTCLR, $urandom | 32'd1, PREDICT, '0);
      push_item(KIND_WRITE, RA_CONTROL, $urandom | 32'h7, PREDICT, '0);

      // mostly ticks and re-arming, with reads, reloads and some noise
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        kind = KIND_WRITE;
        addr = RA_CONTROL;
        data = $urandom;
        if (pick < 50) begin
          kind = KIND_TICK;
        end else if (pick < 62) begin
          if ($urandom_range(0, 3) != 0) data[CTRL_ALARM:CTRL_RUN] = 2'b11;
        end else if (pick < 67) begin
          addr = RA_LOAD;
        end else if (pick < 71) begin
          addr = RA_LATCH;
        end else if (pick < 76) begin
          addr = RA_INTCLR;
        end else if (pick < 79) begin
          addr = RA_INTENA;
        end else if (pick < 83) begin
          addr = ($urandom_range(0, 1) != 0) ? RA_LOADLO : RA_LOADHI;
          if ($urandom_range(0, 1) != 0)
            data = (addr == RA_LOADLO) ? base[31:0] : base[63:32];
        end else if (pick < 93) begin
          kind = KIND_READ;
          addr = 4'($urandom_range(0, 15));
        end else if (pick < 96) begin
          addr = 4'($urandom_range(0, 15));
        end else begin
          kind = ($urandom_range(0, 1) != 0) ? KIND_NONE : 2'($urandom_range(0, 3));
          addr = 4'($urandom_range(0, 15));
        end
        push_item(kind, addr, data, PREDICT, '0);
      end
    end

    in_tvalid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    $display("tb_top: %0d items under %0d timer settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("tb_top: %0d alarms fired, %0d mismatches, %0d results left over",
             alarm_hits, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
